### hw/rtl/whl_pkg.sv
package whl_pkg;

    // Job kinds decided by the front part.
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_SKIP   = 2'd1;
    localparam logic [1:0] KIND_TRANSP = 2'd2;
    localparam logic [1:0] KIND_INCL   = 2'd3;

    // Rec.709 luma weights in Q16 and the rounding offset.
    localparam int unsigned COEF_BITS = 16;
    localparam int unsigned KR        = 13933;
    localparam int unsigned KG        = 46871;
    localparam int unsigned KB        = 4732;
    localparam int unsigned ROUND     = 32768;

    // Weight used when coverage is not selected.
    localparam int unsigned WEIGHT_BITS = 8;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = 8'd255;

    // Register index of use_coverage.
    localparam logic REG_USE_COVERAGE = 1'b0;

    // Depth of the queue between front and back.
    localparam int unsigned FIFO_DEPTH = 2;

    // Control part of one queued job.
    typedef struct packed {
        logic [1:0]             kind;
        logic [WEIGHT_BITS-1:0] weight;
    } t_job_ctl;

endpackage

### hw/rtl/whl_ram.sv
module whl_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/whl_fifo.sv
module whl_fifo #(
    parameter int unsigned WIDTH = 58,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_BITS = $clog2(DEPTH);
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/whl_front.sv
module whl_front #(
    parameter int unsigned SAMPLE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_req_type,
    input  logic [SAMPLE_BITS-1:0] i_red_sample,
    input  logic [SAMPLE_BITS-1:0] i_green_sample,
    input  logic [SAMPLE_BITS-1:0] i_blue_sample,
    input  logic [SAMPLE_BITS-1:0] i_alpha_sample,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_red,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_green,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_blue,
    input  logic [7:0]             i_coverage,
    input  logic [SAMPLE_BITS-1:0] i_bin_index,
    input  logic                   i_use_coverage,
    input  logic                   i_fifo_full,
    output logic                   o_ready,
    output logic                   o_push,
    output whl_pkg::t_job_ctl      o_ctl,
    output logic [SAMPLE_BITS-1:0] o_red,
    output logic [SAMPLE_BITS-1:0] o_green,
    output logic [SAMPLE_BITS-1:0] o_blue,
    output logic [SAMPLE_BITS-1:0] o_alpha,
    output logic [SAMPLE_BITS-1:0] o_luma
);

    localparam int unsigned PROD_BITS = SAMPLE_BITS + whl_pkg::COEF_BITS;
    localparam int unsigned SUM_BITS  = PROD_BITS + 2;
    localparam int unsigned Y_BITS    = SUM_BITS - whl_pkg::COEF_BITS;

    // First stage: captured beat.
    logic                                r_s1_v;
    logic                                r_s1_req;
    logic [SAMPLE_BITS-1:0]              r_s1_red, r_s1_green, r_s1_blue, r_s1_alpha;
    logic [SAMPLE_BITS-1:0]              r_s1_lr, r_s1_lg, r_s1_lb, r_s1_bin;
    logic [whl_pkg::WEIGHT_BITS-1:0]     r_s1_weight;

    // Second stage: classified job and luma products.
    logic                                r_s2_v;
    whl_pkg::t_job_ctl                   r_s2_ctl;
    logic [SAMPLE_BITS-1:0]              r_s2_red, r_s2_green, r_s2_blue, r_s2_alpha;
    logic [PROD_BITS-1:0]                r_s2_pr, r_s2_pg, r_s2_pb;

    logic [1:0]                          s1_kind;
    logic                                s1_adv;
    logic                                s2_adv;
    logic [SUM_BITS-1:0]                 luma_sum;
    logic [Y_BITS-1:0]                   luma_full;
    logic [SAMPLE_BITS-1:0]              luma_clamped;

    // Classify the captured beat.
    always_comb begin
        if (r_s1_req) begin
            s1_kind = whl_pkg::KIND_READ;
        end else if (r_s1_weight == '0) begin
            s1_kind = whl_pkg::KIND_SKIP;
        end else if (r_s1_alpha == '0) begin
            s1_kind = whl_pkg::KIND_TRANSP;
        end else begin
            s1_kind = whl_pkg::KIND_INCL;
        end
    end

    // Stage flow: skipped jobs leave without a queue slot.
    assign s2_adv  = r_s2_v && (!i_fifo_full || r_s2_ctl.kind == whl_pkg::KIND_SKIP);
    assign s1_adv  = r_s1_v && (!r_s2_v || s2_adv);
    assign o_ready = !r_s1_v || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    // Capture a beat, choosing its weight.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req    <= i_req_type;
            r_s1_red    <= i_red_sample;
            r_s1_green  <= i_green_sample;
            r_s1_blue   <= i_blue_sample;
            r_s1_alpha  <= i_alpha_sample;
            r_s1_lr     <= i_luma_ref_red;
            r_s1_lg     <= i_luma_ref_green;
            r_s1_lb     <= i_luma_ref_blue;
            r_s1_bin    <= i_bin_index;
            r_s1_weight <= i_use_coverage ? i_coverage : whl_pkg::WEIGHT_FULL;
        end
    end

    // Products of the luma weights; a read carries its bin in every channel.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_ctl.kind   <= s1_kind;
            r_s2_ctl.weight <= r_s1_weight;
            r_s2_red        <= r_s1_req ? r_s1_bin : r_s1_red;
            r_s2_green      <= r_s1_req ? r_s1_bin : r_s1_green;
            r_s2_blue       <= r_s1_req ? r_s1_bin : r_s1_blue;
            r_s2_alpha      <= r_s1_req ? r_s1_bin : r_s1_alpha;
            r_s2_pr         <= PROD_BITS'(r_s1_lr) * PROD_BITS'(whl_pkg::KR);
            r_s2_pg         <= PROD_BITS'(r_s1_lg) * PROD_BITS'(whl_pkg::KG);
            r_s2_pb         <= PROD_BITS'(r_s1_lb) * PROD_BITS'(whl_pkg::KB);
        end
    end

    // Round, scale down and clamp the luma.
    always_comb begin
        luma_sum  = SUM_BITS'(r_s2_pr) + SUM_BITS'(r_s2_pg) + SUM_BITS'(r_s2_pb)
                  + SUM_BITS'(whl_pkg::ROUND);
        luma_full = luma_sum[SUM_BITS-1:whl_pkg::COEF_BITS];
        if (luma_full > Y_BITS'({SAMPLE_BITS{1'b1}})) begin
            luma_clamped = '1;
        end else begin
            luma_clamped = luma_full[SAMPLE_BITS-1:0];
        end
    end

    assign o_push  = r_s2_v && !i_fifo_full && (r_s2_ctl.kind != whl_pkg::KIND_SKIP);
    assign o_ctl   = r_s2_ctl;
    assign o_red   = r_s2_red;
    assign o_green = r_s2_green;
    assign o_blue  = r_s2_blue;
    assign o_alpha = r_s2_alpha;
    assign o_luma  = (r_s2_ctl.kind == whl_pkg::KIND_READ) ? r_s2_alpha : luma_clamped;

endmodule

### hw/rtl/whl_back.sv
module whl_back #(
    parameter int unsigned SAMPLE_BITS = 8,
    parameter int unsigned COUNT_BITS  = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  whl_pkg::t_job_ctl      i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_red,
    input  logic [SAMPLE_BITS-1:0] i_green,
    input  logic [SAMPLE_BITS-1:0] i_blue,
    input  logic [SAMPLE_BITS-1:0] i_alpha,
    input  logic [SAMPLE_BITS-1:0] i_luma,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_valid,
    output logic [7:0]             o_read_bin,
    output logic [COUNT_BITS-1:0]  o_luma_count,
    output logic [COUNT_BITS-1:0]  o_red_count,
    output logic [COUNT_BITS-1:0]  o_green_count,
    output logic [COUNT_BITS-1:0]  o_blue_count,
    output logic [COUNT_BITS-1:0]  o_alpha_count,
    output logic [COUNT_BITS-1:0]  o_weight_total,
    output logic [COUNT_BITS-1:0]  o_included_total,
    output logic [COUNT_BITS-1:0]  o_transparent_total
);

    localparam int unsigned NBINS = 1 << SAMPLE_BITS;

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;

    logic [1:0]             r_state;
    logic [SAMPLE_BITS-1:0] r_clr_addr;
    whl_pkg::t_job_ctl      r_ctl;
    logic [SAMPLE_BITS-1:0] r_red, r_green, r_blue, r_alpha, r_luma;
    logic [COUNT_BITS-1:0]  r_weight_sum, r_included, r_transparent;

    logic                   r_valid;
    logic [7:0]             r_out_bin;
    logic [COUNT_BITS-1:0]  r_out_luma, r_out_red, r_out_green, r_out_blue, r_out_alpha;
    logic [COUNT_BITS-1:0]  r_out_weight, r_out_incl, r_out_transp;

    logic [COUNT_BITS-1:0]  rd_luma, rd_red, rd_green, rd_blue, rd_alpha;
    logic [COUNT_BITS-1:0]  weight_ext;
    logic                   clr, upd_all, upd_alpha;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    assign clr        = (r_state == ST_CLR);
    assign o_clearing = clr;
    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign weight_ext = COUNT_BITS'(r_ctl.weight);
    assign upd_all    = (r_state == ST_RD) && (r_ctl.kind == whl_pkg::KIND_INCL);
    assign upd_alpha  = (r_state == ST_RD)
                      && (r_ctl.kind == whl_pkg::KIND_INCL || r_ctl.kind == whl_pkg::KIND_TRANSP);

    // Bin memories: read at the pop, written back in the cycle after it.
    whl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_luma (
        .i_clk(i_clk), .i_we(clr || upd_all), .i_waddr(clr ? r_clr_addr : r_luma),
        .i_wdata(clr ? '0 : sat_add(rd_luma, weight_ext)), .i_raddr(i_luma),
        .o_rdata(rd_luma)
    );
    whl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_red (
        .i_clk(i_clk), .i_we(clr || upd_all), .i_waddr(clr ? r_clr_addr : r_red),
        .i_wdata(clr ? '0 : sat_add(rd_red, weight_ext)), .i_raddr(i_red),
        .o_rdata(rd_red)
    );
    whl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_green (
        .i_clk(i_clk), .i_we(clr || upd_all), .i_waddr(clr ? r_clr_addr : r_green),
        .i_wdata(clr ? '0 : sat_add(rd_green, weight_ext)), .i_raddr(i_green),
        .o_rdata(rd_green)
    );
    whl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_blue (
        .i_clk(i_clk), .i_we(clr || upd_all), .i_waddr(clr ? r_clr_addr : r_blue),
        .i_wdata(clr ? '0 : sat_add(rd_blue, weight_ext)), .i_raddr(i_blue),
        .o_rdata(rd_blue)
    );
    whl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NBINS)) u_alpha (
        .i_clk(i_clk), .i_we(clr || upd_alpha), .i_waddr(clr ? r_clr_addr : r_alpha),
        .i_wdata(clr ? '0 : sat_add(rd_alpha, weight_ext)), .i_raddr(i_alpha),
        .o_rdata(rd_alpha)
    );

    // Sequencer: clearing pass, then one job per read and write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Job held while its bins are read.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl   <= i_ctl;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_alpha <= i_alpha;
            r_luma  <= i_luma;
        end
    end

    // Running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_sum  <= '0;
            r_included    <= '0;
            r_transparent <= '0;
        end else if (r_state == ST_RD) begin
            if (r_ctl.kind == whl_pkg::KIND_INCL) begin
                r_weight_sum <= sat_add(r_weight_sum, weight_ext);
                r_included   <= sat_add(r_included, COUNT_BITS'(1));
            end else if (r_ctl.kind == whl_pkg::KIND_TRANSP) begin
                r_transparent <= sat_add(r_transparent, COUNT_BITS'(1));
            end
        end
    end

    // Result beat for a read job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_RD) && (r_ctl.kind == whl_pkg::KIND_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RD) && (r_ctl.kind == whl_pkg::KIND_READ)) begin
            r_out_bin    <= r_red[7:0];
            r_out_luma   <= rd_luma;
            r_out_red    <= rd_red;
            r_out_green  <= rd_green;
            r_out_blue   <= rd_blue;
            r_out_alpha  <= rd_alpha;
            r_out_weight <= r_weight_sum;
            r_out_incl   <= r_included;
            r_out_transp <= r_transparent;
        end
    end

    assign o_valid             = r_valid;
    assign o_read_bin          = r_out_bin;
    assign o_luma_count        = r_out_luma;
    assign o_red_count         = r_out_red;
    assign o_green_count       = r_out_green;
    assign o_blue_count        = r_out_blue;
    assign o_alpha_count       = r_out_alpha;
    assign o_weight_total      = r_out_weight;
    assign o_included_total    = r_out_incl;
    assign o_transparent_total = r_out_transp;

`ifndef SYNTHESIS
    // A result beat follows only a read job in its read cycle.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_RD && $past(r_ctl.kind) == whl_pkg::KIND_READ))
        else $error("result beat without a read job");

    // No job leaves the queue during the clearing pass.
    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |-> !o_pop)
        else $error("pop during clearing pass");

    // Included count never falls.
    a_incl_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_included >= $past(r_included)))
        else $error("included count decreased");
`endif

endmodule

### hw/rtl/weighted_rgba_luma_histogram.sv
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+------------------------------
// request   | in        | start high, busy low           | req_type, samples, coverage, bin
// result    | out       | o_valid high for one cycle     | read_bin, five counts, totals
// config    | in/out    | psel, penable, pwrite, pready  | use_coverage at byte 0
//
// A request passes the front stages s1 and s2, then a bin read and a write-back
// in the back part; the back part's read-modify-write of the bin memories lets
// it take a new job from the queue only after the last job's write-back.
// A read result passes the front stages, the queue and the back part's read state.
// After reset a clearing pass zeroes all 2^SAMPLE_BITS bins of the bin memories;
// busy stays high during it. Reset is synchronous and active low.
// The receiver cannot stall; busy rises while clearing or when the full queue backs up.
module weighted_rgba_luma_histogram #(
    parameter int unsigned SAMPLE_BITS = 8,
    parameter int unsigned COUNT_BITS  = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_req_type,
    input  logic [SAMPLE_BITS-1:0] i_red_sample,
    input  logic [SAMPLE_BITS-1:0] i_green_sample,
    input  logic [SAMPLE_BITS-1:0] i_blue_sample,
    input  logic [SAMPLE_BITS-1:0] i_alpha_sample,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_red,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_green,
    input  logic [SAMPLE_BITS-1:0] i_luma_ref_blue,
    input  logic [7:0]             i_coverage,
    input  logic [SAMPLE_BITS-1:0] i_bin_index,
    output logic                   o_valid,
    output logic [7:0]             o_read_bin,
    output logic [COUNT_BITS-1:0]  o_luma_count,
    output logic [COUNT_BITS-1:0]  o_red_count,
    output logic [COUNT_BITS-1:0]  o_green_count,
    output logic [COUNT_BITS-1:0]  o_blue_count,
    output logic [COUNT_BITS-1:0]  o_alpha_count,
    output logic [COUNT_BITS-1:0]  o_weight_total,
    output logic [COUNT_BITS-1:0]  o_included_total,
    output logic [COUNT_BITS-1:0]  o_transparent_total,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned CTL_BITS = $bits(whl_pkg::t_job_ctl);
    localparam int unsigned JOB_BITS = CTL_BITS + 5 * SAMPLE_BITS;

    logic                   r_use_coverage;
    logic                   accept;
    logic                   front_ready;
    logic                   clearing;
    logic                   push, pop, fifo_full, fifo_empty;
    whl_pkg::t_job_ctl      f_ctl, b_ctl;
    logic [SAMPLE_BITS-1:0] f_red, f_green, f_blue, f_alpha, f_luma;
    logic [SAMPLE_BITS-1:0] b_red, b_green, b_blue, b_alpha, b_luma;
    logic [JOB_BITS-1:0]    q_in, q_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_coverage <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == whl_pkg::REG_USE_COVERAGE) begin
            r_use_coverage <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == whl_pkg::REG_USE_COVERAGE) ? {31'b0, r_use_coverage} : '0;

    // Request handshake.
    assign busy   = clearing || !front_ready;
    assign accept = start && !busy;

    whl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_req_type(i_req_type), .i_red_sample(i_red_sample),
        .i_green_sample(i_green_sample), .i_blue_sample(i_blue_sample),
        .i_alpha_sample(i_alpha_sample), .i_luma_ref_red(i_luma_ref_red),
        .i_luma_ref_green(i_luma_ref_green), .i_luma_ref_blue(i_luma_ref_blue),
        .i_coverage(i_coverage), .i_bin_index(i_bin_index),
        .i_use_coverage(r_use_coverage), .i_fifo_full(fifo_full),
        .o_ready(front_ready), .o_push(push), .o_ctl(f_ctl),
        .o_red(f_red), .o_green(f_green), .o_blue(f_blue),
        .o_alpha(f_alpha), .o_luma(f_luma)
    );

    // Job queue between front and back.
    assign q_in = {f_ctl, f_red, f_green, f_blue, f_alpha, f_luma};
    assign {b_ctl, b_red, b_green, b_blue, b_alpha, b_luma} = q_out;

    whl_fifo #(.WIDTH(JOB_BITS), .DEPTH(whl_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(q_in),
        .i_pop(pop), .o_data(q_out), .o_full(fifo_full), .o_empty(fifo_empty)
    );

    whl_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(fifo_empty), .i_ctl(b_ctl),
        .i_red(b_red), .i_green(b_green), .i_blue(b_blue), .i_alpha(b_alpha),
        .i_luma(b_luma), .o_pop(pop), .o_clearing(clearing), .o_valid(o_valid),
        .o_read_bin(o_read_bin), .o_luma_count(o_luma_count),
        .o_red_count(o_red_count), .o_green_count(o_green_count),
        .o_blue_count(o_blue_count), .o_alpha_count(o_alpha_count),
        .o_weight_total(o_weight_total), .o_included_total(o_included_total),
        .o_transparent_total(o_transparent_total)
    );

endmodule
